// ----- rtl/core/rsc_pkg.sv -----
`default_nettype none

package rsc_pkg;

  // Full width of a packed text key on the ports
  localparam int TEXT_W  = 64;
  localparam int VALUE_W = 32;

  // sort_column codes
  localparam logic [1:0] COL_NONE   = 2'd0;
  localparam logic [1:0] COL_FIRST  = 2'd1;
  localparam logic [1:0] COL_VALUE  = 2'd2;
  localparam logic [1:0] COL_SECOND = 2'd3;

  typedef enum logic [6:0] {
    S_LOAD      = 7'b0000001,
    S_FETCH     = 7'b0000010,
    S_HOLD      = 7'b0000100,
    S_CMP       = 7'b0001000,
    S_PLACE     = 7'b0010000,
    S_EMIT_RD   = 7'b0100000,
    S_EMIT_WAIT = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rsc_ram.sv -----
`default_nettype none

module rsc_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rsc_cmp.sv -----
`default_nettype none

// Record layout: {first_text, value, second_text}, text keys TW bits each.
module rsc_cmp
  import rsc_pkg::*;
#(
  parameter int TW = 64
) (
  input  wire logic [2*TW+VALUE_W-1:0] rec_a,
  input  wire logic [2*TW+VALUE_W-1:0] rec_b,
  input  wire logic [1:0]              col,
  output logic                         a_gt_b
);

  localparam int RW = 2*TW + VALUE_W;

  logic [TW-1:0]             a_first, b_first, a_second, b_second;
  logic signed [VALUE_W-1:0] a_val, b_val;

  assign a_first  = rec_a[RW-1 -: TW];
  assign b_first  = rec_b[RW-1 -: TW];
  assign a_val    = rec_a[TW +: VALUE_W];
  assign b_val    = rec_b[TW +: VALUE_W];
  assign a_second = rec_a[TW-1:0];
  assign b_second = rec_b[TW-1:0];

  always_comb begin
    case (col)
      COL_FIRST:  a_gt_b = a_first > b_first;
      COL_VALUE:  a_gt_b = a_val > b_val;
      COL_SECOND: a_gt_b = a_second > b_second;
      default:    a_gt_b = 1'b0;  // no column: arrival order
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/record_sorter_by_column.sv -----
// Load: one record per cycle, in_ready high while collecting a set.
// Sort (n >= 2): in-place insertion sort through one registered-read RAM port; a
//   fetch state reads the first record to insert, S_HOLD keeps it, S_CMP shifts each
//   neighbor that ranks above it up one slot or writes it at its hole, S_PLACE at slot 0.
// Emit: one read state (S_EMIT_RD) ahead of the first result, then one transfer per cycle while out_ready is high.
// Reset (rst_n low, synchronous): empty set, overflow clear, sort_column = 1.
`default_nettype none

module record_sorter_by_column
  import rsc_pkg::*;
#(
  parameter int MAX_RECORDS = 16,
  parameter int TEXT_BYTES  = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration: sort_column
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_data,
  // record input
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [TEXT_W-1:0]         in_first_text,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [TEXT_W-1:0]         in_second_text,
  input  wire logic                      in_final_record,
  // sorted output
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [TEXT_W-1:0]              out_first_text,
  output logic signed [VALUE_W-1:0]      out_value,
  output logic [TEXT_W-1:0]              out_second_text,
  output logic                           out_final,
  output logic                           out_overflowed
);

  // Only the leading TEXT_BYTES bytes of a key are kept; the rest read back as zero.
  localparam int TW  = 8 * TEXT_BYTES;
  localparam int PAD = TEXT_W - TW;
  localparam int RW  = 2*TW + VALUE_W;
  localparam int AW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);   // count holds 0..MAX_RECORDS

  state_t          state_r, state_nxt;
  logic [1:0]      sort_col_r;
  logic [CW-1:0]   count_r, count_nxt;    // records held in the set
  logic [CW-1:0]   n_r, n_nxt;            // size of the set being sorted / emitted
  logic [CW-1:0]   i_r, i_nxt;            // insertion sort outer index
  logic [AW-1:0]   j_r, j_nxt;            // hole position
  logic [AW-1:0]   k_r, k_nxt;            // emit index
  logic            ovf_r, ovf_nxt;
  logic [RW-1:0]   held_r, held_nxt;      // record being inserted

  // RAM port signals
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [RW-1:0]   wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [RW-1:0]   rd_data;

  logic            in_xfer, out_xfer, store_ok, gt;
  logic [CW-1:0]   i_inc;
  logic [AW-1:0]   j_dec;
  logic            emit_last;
  logic [RW-1:0]   in_rec;

  assign in_rec = {in_first_text[TEXT_W-1 -: TW], in_value, in_second_text[TEXT_W-1 -: TW]};

  rsc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // rd_data holds store[j-1] in S_CMP, compared against the held record
  rsc_cmp #(
    .TW (TW)
  ) u_cmp (
    .rec_a  (rd_data),
    .rec_b  (held_r),
    .col    (sort_col_r),
    .a_gt_b (gt)
  );

  // Config must be written only while idle; the block does not enforce this and always takes it.
  assign cfg_ready = 1'b1;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT_WAIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign store_ok  = (count_r < CW'(MAX_RECORDS));
  assign i_inc     = i_r + CW'(1);
  assign j_dec     = j_r - AW'(1);
  assign emit_last = ((CW'(k_r) + CW'(1)) == n_r);

  // RAM output register holds the emitted record while the transfer is stalled
  assign out_first_text  = TEXT_W'(rd_data[RW-1 -: TW]) << PAD;
  assign out_value       = rd_data[TW +: VALUE_W];
  assign out_second_text = TEXT_W'(rd_data[TW-1:0]) << PAD;
  assign out_final       = emit_last;
  assign out_overflowed  = ovf_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    held_nxt  = held_r;
    wr_en     = 1'b0;
    wr_addr   = j_r;
    wr_data   = held_r;
    rd_en     = 1'b0;
    rd_addr   = k_r;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (store_ok) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = in_rec;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;   // full: record dropped
          end
          if (in_final_record) begin
            n_nxt = store_ok ? count_r + CW'(1) : count_r;
            i_nxt = CW'(1);
            k_nxt = '0;
            state_nxt = (n_nxt > CW'(1)) ? S_FETCH : S_EMIT_RD;
          end
        end
      end

      S_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = i_r[AW-1:0];
        j_nxt     = i_r[AW-1:0];
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        held_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = j_dec;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        wr_en = 1'b1;
        if (gt) begin
          // shift neighbor up one slot; next read never hits this write
          wr_data = rd_data;
          j_nxt   = j_dec;
          if (j_dec != '0) begin
            rd_en   = 1'b1;
            rd_addr = j_dec - AW'(1);
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          wr_data = held_r;
          i_nxt   = i_inc;
          if (i_inc < n_r) begin
            rd_en     = 1'b1;
            rd_addr   = i_inc[AW-1:0];
            j_nxt     = i_inc[AW-1:0];
            state_nxt = S_HOLD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = held_r;
        i_nxt   = i_inc;
        if (i_inc < n_r) begin
          rd_en     = 1'b1;
          rd_addr   = i_inc[AW-1:0];
          j_nxt     = i_inc[AW-1:0];
          state_nxt = S_HOLD;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        if (out_xfer) begin
          if (emit_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt   = k_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = k_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      sort_col_r <= COL_FIRST;
      count_r    <= '0;
      n_r        <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_valid && cfg_ready) begin
        sort_col_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

`default_nettype wire

// ----- test/sorted_record_checker.sv -----
`timescale 1ns / 1ps

module sorted_record_checker
  import rsc_pkg::*;
#(
  parameter int MAX_RECORDS = 16,
  parameter int TEXT_BYTES  = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [1:0]                cfg_data,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic [TEXT_W-1:0]         in_first_text,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [TEXT_W-1:0]         in_second_text,
  input  wire logic                      in_final_record,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [TEXT_W-1:0]         out_first_text,
  input  wire logic signed [VALUE_W-1:0] out_value,
  input  wire logic [TEXT_W-1:0]         out_second_text,
  input  wire logic                      out_final,
  input  wire logic                      out_overflowed,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  // only the leading TEXT_BYTES bytes of a text key survive storage
  localparam logic [TEXT_W-1:0] TEXT_KEEP = {TEXT_W{1'b1}} << (TEXT_W - 8 * TEXT_BYTES);

  typedef struct packed {
    logic [TEXT_W-1:0]  first_text;
    logic [VALUE_W-1:0] value;
    logic [TEXT_W-1:0]  second_text;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    is_last;
    logic    lost;
  } sorted_row_t;

  record_t     held [MAX_RECORDS];
  int          held_count;
  logic        lost_any;
  logic [1:0]  column;
  sorted_row_t sorted_rows [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    held_count = 0;
    lost_any   = 1'b0;
    column     = COL_FIRST;
  end

  // strictly greater key under the selected column; ties keep arrival order
  function automatic logic ranks_after(record_t a, record_t b, logic [1:0] col);
    case (col)
      COL_FIRST:  return a.first_text > b.first_text;
      COL_VALUE:  return $signed(a.value) > $signed(b.value);
      COL_SECOND: return a.second_text > b.second_text;
      default:    return 1'b0;
    endcase
  endfunction

  // stable insertion sort of the held set, then queue every row
  task automatic sort_and_queue();
    record_t     moving;
    sorted_row_t row;
    int          j;
    for (int i = 1; i < held_count; i++) begin
      moving = held[i];
      j = i;
      while (j > 0 && ranks_after(held[j-1], moving, column)) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = moving;
    end
    for (int k = 0; k < held_count; k++) begin
      row.rec     = held[k];
      row.is_last = (k == held_count - 1);
      row.lost    = lost_any;
      sorted_rows.push_back(row);
    end
    held_count = 0;
    lost_any   = 1'b0;
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sorted_row_t want;
    record_t     rec;
    if (!rst_n) begin
      held_count = 0;
      lost_any   = 1'b0;
      column     = COL_FIRST;
      sorted_rows.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_rows.size() == 0) begin
          fail_count++;
          $display("%0t ns: row expected none actual %h %h %h", $time,
                   out_first_text, out_value, out_second_text);
        end else begin
          want = sorted_rows.pop_front();
          checked++;
          compare_field("first_text", want.rec.first_text, out_first_text);
          compare_field("value", {32'b0, want.rec.value}, {32'b0, out_value});
          compare_field("second_text", want.rec.second_text, out_second_text);
          compare_field("final", {63'b0, want.is_last}, {63'b0, out_final});
          compare_field("overflowed", {63'b0, want.lost}, {63'b0, out_overflowed});
        end
      end
      if (cfg_valid && cfg_ready)
        column = cfg_data;
      if (in_valid && in_ready) begin
        rec.first_text  = in_first_text & TEXT_KEEP;
        rec.value       = in_value;
        rec.second_text = in_second_text & TEXT_KEEP;
        if (held_count < MAX_RECORDS) begin
          held[held_count] = rec;
          held_count++;
        end else begin
          lost_any = 1'b1;
        end
        if (in_final_record)
          sort_and_queue();
      end
    end
    pending = sorted_rows.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rsc_pkg::*;

  localparam int MAX_RECORDS  = 16;
  localparam int TEXT_BYTES   = 8;
  // longest quiet stretch: covers a full 16-record sort, plus stalls
  localparam int QUIET_LIMIT  = 4000;
  localparam int RECORD_GOAL  = 430;
  // settle time before a column write once the last row is out
  localparam int SETTLE_TICKS = 8;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      cfg_valid       = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_data        = COL_FIRST;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [TEXT_W-1:0]         in_first_text   = '0;
  logic signed [VALUE_W-1:0] in_value        = '0;
  logic [TEXT_W-1:0]         in_second_text  = '0;
  logic                      in_final_record = 1'b0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic [TEXT_W-1:0]         out_first_text;
  logic signed [VALUE_W-1:0] out_value;
  logic [TEXT_W-1:0]         out_second_text;
  logic                      out_final;
  logic                      out_overflowed;

  int fail_count;
  int pending;
  int checked;

  bit idle_on         = 1'b1;
  int records_sent    = 0;
  int sets_sent       = 0;
  int sets_overflowed = 0;
  int set_fill        = 0;
  int quiet           = 0;

  record_sorter_by_column #(
    .MAX_RECORDS (MAX_RECORDS),
    .TEXT_BYTES  (TEXT_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_text   (in_first_text),
    .in_value        (in_value),
    .in_second_text  (in_second_text),
    .in_final_record (in_final_record),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_first_text  (out_first_text),
    .out_value       (out_value),
    .out_second_text (out_second_text),
    .out_final       (out_final),
    .out_overflowed  (out_overflowed)
  );

  sorted_record_checker #(
    .MAX_RECORDS (MAX_RECORDS),
    .TEXT_BYTES  (TEXT_BYTES)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_text   (in_first_text),
    .in_value        (in_value),
    .in_second_text  (in_second_text),
    .in_final_record (in_final_record),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_first_text  (out_first_text),
    .out_value       (out_value),
    .out_second_text (out_second_text),
    .out_final       (out_final),
    .out_overflowed  (out_overflowed),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result-side back-pressure: ~15% stall, none during the no-idling stretch
  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // watchdog: any transfer on any channel resets the quiet counter
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // text key: raw random word, a small pool that forces ties (one with an
  // interior zero byte), or a short lowercase string, zero padded
  function automatic logic [TEXT_W-1:0] rand_text();
    logic [TEXT_W-1:0] t;
    int                len;
    t = '0;
    case ($urandom_range(3))
      0: t = {$urandom, $urandom};
      1: begin
        case ($urandom_range(3))
          0: t = 64'h0;
          1: t = 64'hFFFF_FFFF_FFFF_FFFF;
          2: t = 64'h6162_6300_0000_0000;
          default: t = 64'h6162_0063_0000_0000;
        endcase
      end
      default: begin
        len = $urandom_range(8);
        for (int b = 0; b < len; b++)
          t[TEXT_W-1-8*b -: 8] = 8'h61 + 8'($urandom_range(25));
      end
    endcase
    return t;
  endfunction

  // numeric key: full range, a narrow band for ties, or an extreme
  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0, 1: v = $urandom;
      2: v = int'($urandom_range(6)) - 3;
      default: begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sh0;
          default: v = -32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // one record transfer; entered and left at a falling edge. in_valid stays
  // high into the next record unless a random gap is taken first.
  // A gap is taken with a 7% chance, which idles about 15% of load cycles.
  task automatic push_record(logic [TEXT_W-1:0] ft, logic signed [VALUE_W-1:0] v,
                             logic [TEXT_W-1:0] st, logic fin);
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_first_text   <= ft;
    in_value        <= v;
    in_second_text  <= st;
    in_final_record <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    records_sent++;
    set_fill++;
    if (fin) begin
      sets_sent++;
      if (set_fill > MAX_RECORDS)
        sets_overflowed++;
      set_fill = 0;
    end
    // long stretch with no idling on either side
    idle_on = !(records_sent >= 180 && records_sent < 280);
    @(negedge clk);
  endtask

  // column write only once the block has drained its last set
  task automatic write_column(logic [1:0] col);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= col;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_random_set(int n);
    for (int k = 0; k < n; k++)
      push_record(rand_text(), rand_value(), rand_text(), k == n - 1);
  endtask

  initial begin
    int size;
    int pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // reset column (first text): a set of one
    push_record(64'hFFFF_FFFF_FFFF_FFFF, 32'sh8000_0000, 64'h0, 1'b1);
    // first text: tie on "AB", and "A\0B" whose bytes past the zero still count
    push_record(64'h4142_0000_0000_0000, 32'sd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_record(64'h4100_4200_0000_0000, -32'sd1, 64'h0000_0000_0000_0001, 1'b0);
    push_record(64'h4142_0000_0000_0000, 32'sd7, 64'h8000_0000_0000_0000, 1'b0);
    push_record(64'h0, 32'sh7FFF_FFFF, 64'h5A00_0000_0000_0000, 1'b1);

    // numeric column: signed extremes, duplicate minimum keeps order
    write_column(COL_VALUE);
    push_record(64'h1111_0000_0000_0000, 32'sh7FFF_FFFF, 64'h0, 1'b0);
    push_record(64'h2222_0000_0000_0000, 32'sh8000_0000, 64'h0, 1'b0);
    push_record(64'h3333_0000_0000_0000, 32'sh0, 64'h0, 1'b0);
    push_record(64'h4444_0000_0000_0000, -32'sd1, 64'h0, 1'b0);
    push_record(64'h5555_0000_0000_0000, 32'sh8000_0000, 64'h0, 1'b1);

    // second text: unsigned compare across the top bit
    write_column(COL_SECOND);
    push_record(64'h0, 32'sd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_record(64'h0, 32'sd2, 64'h0, 1'b0);
    push_record(64'h0, 32'sd3, 64'h8000_0000_0000_0000, 1'b0);
    push_record(64'h0, 32'sd4, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

    // column zero: rows leave in arrival order
    write_column(COL_NONE);
    push_record(64'hFFFF_0000_0000_0000, 32'sd9, 64'h9, 1'b0);
    push_record(64'h0, -32'sd9, 64'h1, 1'b0);
    push_record(64'h8888_0000_0000_0000, 32'sd0, 64'h5, 1'b1);

    // --- random part ---
    // exactly full, then past capacity (the final record itself is dropped)
    write_column(COL_FIRST);
    push_random_set(MAX_RECORDS);
    write_column(COL_VALUE);
    push_random_set(MAX_RECORDS + 2);

    while (records_sent < RECORD_GOAL) begin
      if ($urandom_range(1) == 1)
        write_column(2'($urandom_range(3)));
      pick = $urandom_range(99);
      if (pick < 70)
        size = $urandom_range(1, 6);
      else if (pick < 85)
        size = $urandom_range(7, MAX_RECORDS - 1);
      else if (pick < 93)
        size = MAX_RECORDS;
      else
        size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
      push_random_set(size);
    end

    // drain, then let the block sit a little before the verdict
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d records in %0d sets (%0d past capacity) across all column settings.",
             records_sent, sets_sent, sets_overflowed);
    $display("Checked %0d sorted rows, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rsc_pkg.sv
rtl/core/rsc_ram.sv
rtl/core/rsc_cmp.sv
rtl/core/record_sorter_by_column.sv
test/sorted_record_checker.sv
test/tb.sv
